/* hw/rtl/mt64_pkg.sv */
package mt64_pkg;

    // Table geometry
    localparam int STATE_DEPTH   = 312;
    localparam int MIDDLE_OFFSET = 156;
    localparam int ADDR_W        = $clog2(STATE_DEPTH);
    localparam int WORD_W        = 64;
    localparam int HALF_W        = WORD_W / 2;

    // word_index code for a table that has never been seeded
    localparam logic [ADDR_W-1:0] UNSEEDED_MARK = ADDR_W'(STATE_DEPTH + 1);

    // Seeding recurrence multiplier and its halves
    localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
    localparam logic [HALF_W-1:0] SEED_MULT_LO = SEED_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] SEED_MULT_HI = SEED_MULT[WORD_W-1:HALF_W];
    localparam logic [WORD_W-1:0] SEED_RESET   = 64'd5489;

    // Twist constants: upper part is bits 63..31, lower part bits 30..0
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB5026F5AA96619E9;
    localparam int                LOW_BITS     = 31;

    // Tempering masks
    localparam logic [WORD_W-1:0] TEMPER_MASK_A = 64'h5555555555555555;
    localparam logic [WORD_W-1:0] TEMPER_MASK_B = 64'h71D67FFFEDA60000;
    localparam logic [WORD_W-1:0] TEMPER_MASK_C = 64'hFFF7EEE000000000;

    // Request from the sequencer to the state table
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

    // Output tempering, four shift-and-xor steps, the first three masked
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ ((y >> 29) & TEMPER_MASK_A);
        y = y ^ ((y << 17) & TEMPER_MASK_B);
        y = y ^ ((y << 37) & TEMPER_MASK_C);
        y = y ^ (y >> 43);
        return y;
    endfunction

endpackage

/* hw/rtl/mt64_mul.sv */
module mt64_mul (
    input  logic                           i_clk,
    input  logic [mt64_pkg::HALF_W-1:0]    i_a,
    input  logic [mt64_pkg::HALF_W-1:0]    i_b,
    output logic [mt64_pkg::WORD_W-1:0]    o_p
);

    // Shared 32x32 multiplier, product registered
    logic [mt64_pkg::WORD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= mt64_pkg::WORD_W'(i_a) * mt64_pkg::WORD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/mt64_state_ram.sv */
module mt64_state_ram (
    input  logic                           i_clk,
    input  mt64_pkg::t_ram_req             i_req,
    output logic [mt64_pkg::WORD_W-1:0]    o_rd_a,
    output logic [mt64_pkg::WORD_W-1:0]    o_rd_b
);

    // State table: one write port, two registered read ports
    logic [mt64_pkg::WORD_W-1:0] r_mem [mt64_pkg::STATE_DEPTH];
    logic [mt64_pkg::WORD_W-1:0] r_rd_a;
    logic [mt64_pkg::WORD_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        // read data holds while no read is issued
        if (i_req.re) begin
            r_rd_a <= r_mem[i_req.raddr_a];
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

/* hw/rtl/mersenne_twister_64_generator.sv */
// 64-bit Mersenne Twister word generator (MT19937-64).
//
// Channels: request (i_valid/o_ready, i_reseed), result (o_valid/i_ready,
// o_random_word) and seed write (i_cfg_valid/o_cfg_ready, i_cfg_data).
// Each request transfer yields exactly one tempered 64-bit word.
// A plain draw is one table read plus tempering; a new request is taken
// only when the sequencer is idle again. Every 312th draw first twists the
// whole table, word by word (read current and next word, read the far word,
// write). Seeding (first request after reset, or i_reseed = 1) runs the
// multiplier recurrence through one shared 32x32 multiplier, word by word
// (three partial products, then the write), then twists and draws.
// Reset sets the seed register to 5489 and marks the table unseeded; the
// table itself is not cleared. The result sits in an output register: if
// the receiver stalls, the next request is still taken and processed, and
// the sequencer waits only when that next word is ready to be registered.
// Seed writes are always accepted and take effect at the next seeding.
module mersenne_twister_64_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_reseed,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mt64_pkg::WORD_W-1:0]    o_random_word,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mt64_pkg::WORD_W-1:0]    i_cfg_data
);

    localparam int AW = mt64_pkg::ADDR_W;
    localparam int WW = mt64_pkg::WORD_W;
    localparam int HW = mt64_pkg::HALF_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_INIT,
        ST_SEED_M0,
        ST_SEED_M1,
        ST_SEED_M2,
        ST_SEED_WR,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_WR,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } t_state;

    t_state               r_state;
    logic [WW-1:0]        r_seed;
    logic [AW-1:0]        r_word_idx;
    logic [AW-1:0]        r_k;
    logic [WW-1:0]        r_p;
    logic [WW-1:0]        r_acc;
    logic [WW-1:0]        r_y;
    logic                 r_valid;
    logic [WW-1:0]        r_out;

    mt64_pkg::t_ram_req   ram_req;
    logic [WW-1:0]        rd_a;
    logic [WW-1:0]        rd_b;
    logic [HW-1:0]        mul_a;
    logic [HW-1:0]        mul_b;
    logic [WW-1:0]        mul_p;

    logic [WW-1:0]        seed_x;
    logic [WW-1:0]        seed_word;
    logic [AW-1:0]        tw_next;
    logic [AW:0]          far_sum;
    logic [AW-1:0]        tw_far;
    logic [WW-1:0]        tw_word;
    logic                 last_k;
    logic                 out_load;

    mt64_state_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    mt64_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Seeding datapath: x = p ^ (p >> 62), product assembled from partials
    assign seed_x    = r_p ^ (r_p >> 62);
    assign seed_word = r_acc + {mul_p[HW-1:0], HW'(0)};

    // Twist neighbors with wraparound
    assign last_k  = (r_k == AW'(mt64_pkg::STATE_DEPTH - 1));
    assign tw_next = last_k ? '0 : r_k + AW'(1);
    assign far_sum = {1'b0, r_k} + (AW+1)'(mt64_pkg::MIDDLE_OFFSET);
    assign tw_far  = (far_sum >= (AW+1)'(mt64_pkg::STATE_DEPTH))
                   ? AW'(far_sum - (AW+1)'(mt64_pkg::STATE_DEPTH))
                   : far_sum[AW-1:0];
    assign tw_word = rd_a ^ (r_y >> 1) ^ (r_y[0] ? mt64_pkg::TWIST_MATRIX : '0);

    // Output register loads once the previous word is gone or leaving
    assign out_load = (r_state == ST_DRAW_OUT) && (!r_valid || i_ready);

    // Multiplier operand select: lo*lo, hi*lo, lo*hi
    always_comb begin
        unique case (r_state)
            ST_SEED_M1: begin
                mul_a = seed_x[WW-1:HW];
                mul_b = mt64_pkg::SEED_MULT_LO;
            end
            ST_SEED_M2: begin
                mul_a = seed_x[HW-1:0];
                mul_b = mt64_pkg::SEED_MULT_HI;
            end
            default: begin
                mul_a = seed_x[HW-1:0];
                mul_b = mt64_pkg::SEED_MULT_LO;
            end
        endcase
    end

    // Table accesses per sequencer state
    always_comb begin
        ram_req = '0;
        unique case (r_state)
            ST_SEED_INIT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = r_seed;
            end
            ST_SEED_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_k;
                ram_req.wdata = seed_word;
            end
            ST_TW_RD0: begin
                ram_req.re      = 1'b1;
                ram_req.raddr_a = r_k;
                ram_req.raddr_b = tw_next;
            end
            ST_TW_RD1: begin
                ram_req.re      = 1'b1;
                ram_req.raddr_a = tw_far;
                ram_req.raddr_b = tw_next;
            end
            ST_TW_WR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_k;
                ram_req.wdata = tw_word;
            end
            ST_DRAW_RD: begin
                ram_req.re      = 1'b1;
                ram_req.raddr_a = r_word_idx;
                ram_req.raddr_b = r_word_idx;
            end
            default: begin
                ram_req = '0;
            end
        endcase
    end

    // Sequencer, seed register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seed     <= mt64_pkg::SEED_RESET;
            r_word_idx <= mt64_pkg::UNSEEDED_MARK;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (out_load) begin
                r_out   <= mt64_pkg::temper(rd_a);
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_reseed || r_word_idx == mt64_pkg::UNSEEDED_MARK) begin
                            r_state <= ST_SEED_INIT;
                        end else if (r_word_idx >= AW'(mt64_pkg::STATE_DEPTH)) begin
                            r_k     <= '0;
                            r_state <= ST_TW_RD0;
                        end else begin
                            r_state <= ST_DRAW_RD;
                        end
                    end
                end
                ST_SEED_INIT: begin
                    r_p     <= r_seed;
                    r_k     <= AW'(1);
                    r_state <= ST_SEED_M0;
                end
                ST_SEED_M0: begin
                    r_state <= ST_SEED_M1;
                end
                ST_SEED_M1: begin
                    // low product plus the index term
                    r_acc   <= mul_p + WW'(r_k);
                    r_state <= ST_SEED_M2;
                end
                ST_SEED_M2: begin
                    r_acc   <= r_acc + {mul_p[HW-1:0], HW'(0)};
                    r_state <= ST_SEED_WR;
                end
                ST_SEED_WR: begin
                    r_p <= seed_word;
                    if (last_k) begin
                        r_k     <= '0;
                        r_state <= ST_TW_RD0;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= ST_SEED_M0;
                    end
                end
                ST_TW_RD0: begin
                    r_state <= ST_TW_RD1;
                end
                ST_TW_RD1: begin
                    // upper bits of word k, lower bits of word k+1
                    r_y     <= {rd_a[WW-1:mt64_pkg::LOW_BITS],
                                rd_b[mt64_pkg::LOW_BITS-1:0]};
                    r_state <= ST_TW_WR;
                end
                ST_TW_WR: begin
                    if (last_k) begin
                        r_word_idx <= '0;
                        r_state    <= ST_DRAW_RD;
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= ST_TW_RD0;
                    end
                end
                ST_DRAW_RD: begin
                    r_word_idx <= r_word_idx + AW'(1);
                    r_state    <= ST_DRAW_OUT;
                end
                ST_DRAW_OUT: begin
                    // wait here only while the previous word is still unclaimed
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_valid;
    assign o_random_word = r_out;
    assign o_cfg_ready   = 1'b1;

    // A request transfer always starts multi-cycle work
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while previous one still in progress");

    // Draws only ever read a seeded, untwisted-pending slot
    a_draw_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW_RD) |-> (r_word_idx < AW'(mt64_pkg::STATE_DEPTH)))
        else $error("draw from out-of-range table index");

    // Table writes stay inside the table
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> (ram_req.waddr < AW'(mt64_pkg::STATE_DEPTH)))
        else $error("table write address out of range");

    // A finished draw is followed by a result transfer opportunity
    a_draw_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW_OUT && (!r_valid || i_ready)) |=> (o_valid && o_ready))
        else $error("completed draw did not load the result register");

endmodule
